// File: rtl/core/csvt_pkg.sv
// Shared types and constants of the CSV record tokenizer.
// Used by csvt_step, csvt_outq, csv_record_tokenizer and csvt_checker.
package csvt_pkg;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] SEP_RESET = 8'h2C;

    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_FIELD  = 2'd1;
    localparam logic [1:0] KIND_RECORD = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    localparam logic [1:0] LBC_EMPTY = 2'd0;
    localparam logic [1:0] LBC_CR    = 2'd1;
    localparam logic [1:0] LBC_MORE  = 2'd2;

    typedef enum logic [1:0] {
        PH_START,
        PH_PLAIN,
        PH_QUOTED,
        PH_QSEEN
    } t_phase;

    typedef struct packed {
        t_phase     phase;
        logic       parity;
        logic [1:0] lbc;
    } t_state;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       run_last;
        logic       unc;
    } t_result;

    typedef struct packed {
        t_state     nxt;
        logic [1:0] count;
        t_result    slot0;
        t_result    slot1;
    } t_step;

    localparam t_state STATE_RESET = '{phase: PH_START, parity: 1'b0, lbc: LBC_EMPTY};

endpackage

// File: rtl/core/csvt_step.sv
// Per-byte next-state and result logic of the CSV record tokenizer.
// Depends on csvt_pkg.
module csvt_step (
    input  logic [7:0]      i_byte,
    input  logic            i_final,
    input  logic [7:0]      i_sep,
    input  csvt_pkg::t_state i_state,
    output csvt_pkg::t_step  o_step
);

    csvt_pkg::t_state  st;
    csvt_pkg::t_result res_a;
    csvt_pkg::t_result res_b;
    logic              has_a;
    logic              par_n;
    logic              ends;
    logic              is_quote;

    assign is_quote = (i_byte == csvt_pkg::CH_QUOTE);
    assign ends     = (i_byte == i_sep) || (i_byte == csvt_pkg::CH_NUL);
    assign par_n    = i_state.parity ^ is_quote;

    always_comb begin
        st    = i_state;
        has_a = 1'b0;
        res_a = '{kind: csvt_pkg::KIND_BYTE, data: 8'h00, run_last: 1'b0, unc: 1'b0};
        st.parity = par_n;
        if ((i_byte == csvt_pkg::CH_LF) && !par_n) begin
            has_a      = 1'b1;
            res_a.kind = csvt_pkg::KIND_RECORD;
            st.phase   = csvt_pkg::PH_START;
            st.lbc     = csvt_pkg::LBC_EMPTY;
        end else begin
            if (i_state.lbc == csvt_pkg::LBC_EMPTY) begin
                st.lbc = (i_byte == csvt_pkg::CH_CR) ? csvt_pkg::LBC_CR : csvt_pkg::LBC_MORE;
            end else begin
                st.lbc = csvt_pkg::LBC_MORE;
            end
            if (i_byte != csvt_pkg::CH_CR) begin
                case (i_state.phase)
                    csvt_pkg::PH_START: begin
                        if (is_quote) begin
                            st.phase = csvt_pkg::PH_QUOTED;
                        end else if (ends) begin
                            has_a      = 1'b1;
                            res_a.kind = csvt_pkg::KIND_FIELD;
                        end else begin
                            st.phase   = csvt_pkg::PH_PLAIN;
                            has_a      = 1'b1;
                            res_a.data = i_byte;
                        end
                    end
                    csvt_pkg::PH_PLAIN: begin
                        has_a = 1'b1;
                        if (ends) begin
                            st.phase   = csvt_pkg::PH_START;
                            res_a.kind = csvt_pkg::KIND_FIELD;
                        end else begin
                            res_a.data = i_byte;
                        end
                    end
                    csvt_pkg::PH_QUOTED: begin
                        if (is_quote) begin
                            st.phase = csvt_pkg::PH_QSEEN;
                        end else if (i_byte == csvt_pkg::CH_NUL) begin
                            st.phase   = csvt_pkg::PH_START;
                            has_a      = 1'b1;
                            res_a.kind = csvt_pkg::KIND_FIELD;
                        end else begin
                            has_a      = 1'b1;
                            res_a.data = i_byte;
                        end
                    end
                    default: begin
                        if (is_quote) begin
                            st.phase   = csvt_pkg::PH_QUOTED;
                            has_a      = 1'b1;
                            res_a.data = csvt_pkg::CH_QUOTE;
                        end else if (ends) begin
                            st.phase   = csvt_pkg::PH_START;
                            has_a      = 1'b1;
                            res_a.kind = csvt_pkg::KIND_FIELD;
                        end else begin
                            st.phase = csvt_pkg::PH_PLAIN;
                        end
                    end
                endcase
            end
        end

        res_b = '{kind: csvt_pkg::KIND_END, data: 8'h00, run_last: 1'b1, unc: par_n};
        if (par_n || (st.lbc == csvt_pkg::LBC_MORE)) begin
            res_b.kind = csvt_pkg::KIND_RECORD;
        end
        res_a.run_last = !i_final;

        if (i_final) begin
            st = csvt_pkg::STATE_RESET;
        end

        o_step.nxt   = st;
        o_step.count = {1'b0, has_a} + {1'b0, i_final};
        o_step.slot0 = has_a ? res_a : res_b;
        o_step.slot1 = res_b;
    end

endmodule

// File: rtl/core/csvt_outq.sv
// Four-entry result queue: takes up to two results per cycle, gives one per cycle while i_ready is high.
// Depends on csvt_pkg.
module csvt_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [1:0]        i_count,
    input  csvt_pkg::t_result i_slot0,
    input  csvt_pkg::t_result i_slot1,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output csvt_pkg::t_result o_head
);

    csvt_pkg::t_result r_mem [4];
    logic [1:0] r_wr;
    logic [1:0] n_wr;
    logic [1:0] r_rd;
    logic [1:0] n_rd;
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    logic [1:0] add;
    logic       pop;

    assign add     = i_push ? i_count : 2'd0;
    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != 3'd0);
    assign o_room  = (r_cnt <= 3'd2);
    assign o_head  = r_mem[r_rd];
    assign n_wr    = r_wr + add;
    assign n_rd    = r_rd + {1'b0, pop};
    assign n_cnt   = r_cnt + {1'b0, add} - {2'b00, pop};

    always_ff @(posedge i_clk) begin
        if (add != 2'd0) begin
            r_mem[r_wr] <= i_slot0;
        end
        if (add == 2'd2) begin
            r_mem[r_wr + 2'd1] <= i_slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: rtl/core/csv_record_tokenizer.sv
// Top level of the streaming CSV record tokenizer: state registers, separator.
// Depends on csvt_pkg, csvt_step and csvt_outq.
//
//  channel   | valid        | ready        | payload
//  ----------+--------------+--------------+-------------------------------------
//  input     | i_in_valid   | o_in_ready   | i_in_byte, i_final_req
//  output    | o_out_valid  | i_out_ready  | o_kind, o_out_byte, o_run_last,
//            |              |              | o_unclosed_quote
//  config    | i_separator_we (no wait)    | i_separator
//
// One input item per cycle while o_in_ready is high; its results are registered in the result queue, in order.
// An item makes zero, one or two results; the output port drains one per cycle while i_out_ready is high.
// The four-entry result queue sets the stall: input is taken while it holds two or fewer.
// Synchronous active-low reset clears the field state, queue and separator (comma).
module csv_record_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_final_req,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_unclosed_quote,
    input  logic       i_separator_we,
    input  logic [7:0] i_separator
);

    logic [7:0]        r_sep;
    csvt_pkg::t_state  r_state;
    csvt_pkg::t_step   step;
    csvt_pkg::t_result head;
    logic              accept;

    assign accept = i_in_valid && o_in_ready;

    csvt_step u_step (
        .i_byte  (i_in_byte),
        .i_final (i_final_req),
        .i_sep   (r_sep),
        .i_state (r_state),
        .o_step  (step)
    );

    csvt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_count (step.count),
        .i_slot0 (step.slot0),
        .i_slot1 (step.slot1),
        .o_room  (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_head  (head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep   <= csvt_pkg::SEP_RESET;
            r_state <= csvt_pkg::STATE_RESET;
        end else begin
            if (i_separator_we) begin
                r_sep <= i_separator;
            end
            if (accept) begin
                r_state <= step.nxt;
            end
        end
    end

    assign o_kind           = head.kind;
    assign o_out_byte       = head.data;
    assign o_run_last       = head.run_last;
    assign o_unclosed_quote = head.unc;

endmodule

// File: rtl/core/csvt_checker.sv
// Port-level checks of the CSV record tokenizer, bound to the top level.
// Depends on csvt_pkg and csv_record_tokenizer.
module csvt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_kind,
    input logic [7:0] o_out_byte,
    input logic       o_run_last,
    input logic       o_unclosed_quote
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind)
            && $stable(o_out_byte) && $stable(o_run_last))
        else $error("output item changed while stalled");

    a_unc_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_unclosed_quote |->
            o_kind == csvt_pkg::KIND_RECORD && o_run_last)
        else $error("unclosed quote flag off a final record end");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != csvt_pkg::KIND_BYTE |-> o_out_byte == 8'h00)
        else $error("nonzero byte on a non-content item");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == csvt_pkg::KIND_END |-> o_run_last && !o_unclosed_quote)
        else $error("input end item not last of its run");

endmodule

bind csv_record_tokenizer csvt_checker u_csvt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_kind           (o_kind),
    .o_out_byte       (o_out_byte),
    .o_run_last       (o_run_last),
    .o_unclosed_quote (o_unclosed_quote)
);

// File: tb/testbench.sv
// Self-checking testbench for csv_record_tokenizer: byte stream in, token items out.
// Depends on csvt_pkg for kinds, phases, character codes and the result struct.
// A local tokenizer model predicts every result; a monitor compares them in order.
module testbench;

    localparam logic [7:0] SEP_SEMI = 8'h3B;
    localparam logic [7:0] SEP_TAB  = 8'h09;
    localparam logic [7:0] SEP_MIN  = 8'h00;
    localparam logic [7:0] SEP_MAX  = 8'hFF;
    localparam int         NUM_SEPS = 8;
    localparam logic [7:0] SEP_SET [0:NUM_SEPS-1] = '{
        csvt_pkg::SEP_RESET, SEP_SEMI, SEP_TAB, SEP_MIN, SEP_MAX,
        csvt_pkg::CH_QUOTE, csvt_pkg::CH_CR, csvt_pkg::CH_LF
    };
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 10000;
    localparam int PHASE_ITEMS   = 350;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       final_req = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       run_last;
    logic       unclosed_quote;
    logic       sep_we = 1'b0;
    logic [7:0] sep_val = 8'h00;

    csvt_pkg::t_result expected_tokens [$];
    csvt_pkg::t_result step_tokens [0:1];
    int                step_count;
    csvt_pkg::t_phase  field_phase;
    logic              quote_parity;
    logic [1:0]        line_fill;
    logic [7:0]        separator;
    int                mismatches = 0;
    int                items_sent = 0;
    int                send_idle_pct = 15;
    int                recv_idle_pct = 60;
    logic [7:0]        line_buf [$];

    csv_record_tokenizer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_in_byte       (in_byte),
        .i_final_req     (final_req),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_kind          (kind),
        .o_out_byte      (out_byte),
        .o_run_last      (run_last),
        .o_unclosed_quote(unclosed_quote),
        .i_separator_we  (sep_we),
        .i_separator     (sep_val)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #3000000;
        $display("testbench: errors");
        $finish;
    end

    function automatic void add_token(logic [1:0] k, logic [7:0] d, logic u);
        step_tokens[step_count] = '{kind: k, data: d, run_last: 1'b0, unc: u};
        step_count++;
    endfunction

    function automatic void clear_model_state();
        field_phase  = csvt_pkg::PH_START;
        quote_parity = 1'b0;
        line_fill    = csvt_pkg::LBC_EMPTY;
    endfunction

    function automatic void tokenize_byte(logic [7:0] b, logic fin);
        logic ends;
        csvt_pkg::t_result r;
        step_count = 0;
        ends = (b == separator) || (b == csvt_pkg::CH_NUL);
        if (b == csvt_pkg::CH_QUOTE) quote_parity = ~quote_parity;
        if (b == csvt_pkg::CH_LF && !quote_parity) begin
            add_token(csvt_pkg::KIND_RECORD, 8'h00, 1'b0);
            field_phase = csvt_pkg::PH_START;
            line_fill   = csvt_pkg::LBC_EMPTY;
        end else begin
            if (line_fill == csvt_pkg::LBC_EMPTY)
                line_fill = (b == csvt_pkg::CH_CR) ? csvt_pkg::LBC_CR : csvt_pkg::LBC_MORE;
            else line_fill = csvt_pkg::LBC_MORE;
            if (b != csvt_pkg::CH_CR) begin
                case (field_phase)
                    csvt_pkg::PH_START: begin
                        if (b == csvt_pkg::CH_QUOTE) field_phase = csvt_pkg::PH_QUOTED;
                        else if (ends) add_token(csvt_pkg::KIND_FIELD, 8'h00, 1'b0);
                        else begin
                            field_phase = csvt_pkg::PH_PLAIN;
                            add_token(csvt_pkg::KIND_BYTE, b, 1'b0);
                        end
                    end
                    csvt_pkg::PH_PLAIN: begin
                        if (ends) begin
                            field_phase = csvt_pkg::PH_START;
                            add_token(csvt_pkg::KIND_FIELD, 8'h00, 1'b0);
                        end else add_token(csvt_pkg::KIND_BYTE, b, 1'b0);
                    end
                    csvt_pkg::PH_QUOTED: begin
                        if (b == csvt_pkg::CH_QUOTE) field_phase = csvt_pkg::PH_QSEEN;
                        else if (b == csvt_pkg::CH_NUL) begin
                            field_phase = csvt_pkg::PH_START;
                            add_token(csvt_pkg::KIND_FIELD, 8'h00, 1'b0);
                        end else add_token(csvt_pkg::KIND_BYTE, b, 1'b0);
                    end
                    default: begin
                        if (b == csvt_pkg::CH_QUOTE) begin
                            field_phase = csvt_pkg::PH_QUOTED;
                            add_token(csvt_pkg::KIND_BYTE, csvt_pkg::CH_QUOTE, 1'b0);
                        end else if (ends) begin
                            field_phase = csvt_pkg::PH_START;
                            add_token(csvt_pkg::KIND_FIELD, 8'h00, 1'b0);
                        end else field_phase = csvt_pkg::PH_PLAIN;
                    end
                endcase
            end
        end
        if (fin) begin
            if (quote_parity) add_token(csvt_pkg::KIND_RECORD, 8'h00, 1'b1);
            else if (line_fill == csvt_pkg::LBC_MORE)
                add_token(csvt_pkg::KIND_RECORD, 8'h00, 1'b0);
            else add_token(csvt_pkg::KIND_END, 8'h00, 1'b0);
            clear_model_state();
        end
        for (int i = 0; i < step_count; i++) begin
            r = step_tokens[i];
            r.run_last = (i == step_count - 1);
            expected_tokens.push_back(r);
        end
    endfunction

    always @(posedge i_clk) begin
        csvt_pkg::t_result e;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_tokens.size() == 0) begin
                $error("unexpected item: kind %0d, out_byte %0h", kind, out_byte);
                mismatches++;
            end else begin
                e = expected_tokens.pop_front();
                if (kind !== e.kind) begin
                    $error("kind: expected %0d, actual %0d", e.kind, kind);
                    mismatches++;
                end
                if (out_byte !== e.data) begin
                    $error("out_byte: expected %0h, actual %0h", e.data, out_byte);
                    mismatches++;
                end
                if (run_last !== e.run_last) begin
                    $error("run_last: expected %0d, actual %0d", e.run_last, run_last);
                    mismatches++;
                end
                if (unclosed_quote !== e.unc) begin
                    $error("unclosed_quote: expected %0d, actual %0d", e.unc, unclosed_quote);
                    mismatches++;
                end
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_item(logic [7:0] b, logic fin);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        in_byte   <= b;
        final_req <= fin;
        do @(posedge i_clk); while (!in_ready);
        tokenize_byte(b, fin);
        items_sent++;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (expected_tokens.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_separator(logic [7:0] v);
        drain();
        sep_we  <= 1'b1;
        sep_val <= v;
        @(posedge i_clk);
        separator = v;
        sep_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (c == separator || c == csvt_pkg::CH_QUOTE || c == csvt_pkg::CH_LF
               || c == csvt_pkg::CH_CR);
        return c;
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 9))
            0: return csvt_pkg::CH_QUOTE;
            1: return separator;
            2: return csvt_pkg::CH_CR;
            3: return csvt_pkg::CH_LF;
            4: return csvt_pkg::CH_NUL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_record();
        int nf;
        int len;
        int r;
        logic fin;
        line_buf.delete();
        nf = $urandom_range(1, 4);
        for (int f = 0; f < nf; f++) begin
            if (f > 0) line_buf.push_back(separator);
            len = $urandom_range(0, 5);
            if ($urandom_range(0, 1)) begin
                line_buf.push_back(csvt_pkg::CH_QUOTE);
                for (int i = 0; i < len; i++) begin
                    r = $urandom_range(0, 9);
                    if (r == 0) begin
                        line_buf.push_back(csvt_pkg::CH_QUOTE);
                        line_buf.push_back(csvt_pkg::CH_QUOTE);
                    end else if (r == 1) line_buf.push_back(separator);
                    else if (r == 2) line_buf.push_back(csvt_pkg::CH_LF);
                    else if (r == 3) line_buf.push_back(csvt_pkg::CH_CR);
                    else line_buf.push_back(plain_byte());
                end
                line_buf.push_back(csvt_pkg::CH_QUOTE);
            end else begin
                for (int i = 0; i < len; i++) line_buf.push_back(plain_byte());
            end
        end
        r = $urandom_range(0, 9);
        if (r < 5) begin
            line_buf.push_back(csvt_pkg::CH_CR);
            line_buf.push_back(csvt_pkg::CH_LF);
        end else if (r < 9) line_buf.push_back(csvt_pkg::CH_LF);
        fin = ($urandom_range(0, 5) == 0);
        for (int i = 0; i < line_buf.size(); i++)
            send_item(line_buf[i], fin && (i == line_buf.size() - 1));
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) send_item(noise_byte(), $urandom_range(0, 9) == 0);
    endtask

    task automatic run_mixed(int count);
        int stop_at;
        int next_pause;
        stop_at    = items_sent + count;
        next_pause = items_sent + 200;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) < 7) send_record();
            else send_noise();
            if (items_sent >= next_pause) begin
                drain();
                next_pause = items_sent + 200;
            end
        end
    endtask

    task automatic test_directed();
        send_item(csvt_pkg::CH_NUL, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(csvt_pkg::SEP_RESET, 1'b0);
        send_item(csvt_pkg::CH_QUOTE, 1'b0);
        send_item(csvt_pkg::SEP_RESET, 1'b0);
        send_item(csvt_pkg::CH_LF, 1'b0);
        send_item(csvt_pkg::CH_QUOTE, 1'b0);
        send_item(csvt_pkg::CH_QUOTE, 1'b0);
        send_item(csvt_pkg::CH_QUOTE, 1'b0);
        send_item(8'h7A, 1'b0);
        send_item(csvt_pkg::CH_QUOTE, 1'b0);
        send_item(csvt_pkg::CH_CR, 1'b0);
        send_item(csvt_pkg::SEP_RESET, 1'b0);
        send_item(csvt_pkg::CH_QUOTE, 1'b0);
        send_item(csvt_pkg::CH_NUL, 1'b0);
        send_item(csvt_pkg::CH_LF, 1'b0);
        send_item(csvt_pkg::CH_CR, 1'b1);
        send_item(csvt_pkg::CH_LF, 1'b1);
        send_item(csvt_pkg::CH_QUOTE, 1'b0);
        send_item(8'h71, 1'b0);
        send_item(8'h01, 1'b1);
        send_item(8'h01, 1'b1);
    endtask

    task automatic test_separator_sweep();
        for (int i = 1; i < NUM_SEPS; i++) begin
            set_separator(SEP_SET[i]);
            run_mixed(50);
            send_item(noise_byte(), 1'b1);
        end
        set_separator(csvt_pkg::SEP_RESET);
    endtask

    task automatic test_random_traffic();
        set_separator(SEP_SET[$urandom_range(0, NUM_SEPS - 1)]);
        run_mixed(PHASE_ITEMS);
        drain();
        send_idle_pct = 60;
        recv_idle_pct = 15;
        set_separator(SEP_SET[$urandom_range(0, NUM_SEPS - 1)]);
        run_mixed(PHASE_ITEMS);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_separator(csvt_pkg::SEP_RESET);
        run_mixed(PHASE_ITEMS);
    endtask

    initial begin
        separator = csvt_pkg::SEP_RESET;
        clear_model_state();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_separator_sweep();
        test_random_traffic();
        drain();
        if (expected_tokens.size() != 0) begin
            $error("%0d expected items never arrived", expected_tokens.size());
            mismatches++;
        end
        if (mismatches == 0) $display("testbench: clean");
        else $display("testbench: errors");
        $finish;
    end

endmodule
